@@ sv/jsu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Field widths of the two channels
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ErrW    = 3;

  // Code point width (up to U+10FFFF)
  localparam int unsigned CpW = 21;

  // Character codes
  localparam logic [ByteW-1:0] ChQuote     = 8'h22;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSlash     = 8'h2F;
  localparam logic [ByteW-1:0] ChLowB      = 8'h62;
  localparam logic [ByteW-1:0] ChLowF      = 8'h66;
  localparam logic [ByteW-1:0] ChLowN      = 8'h6E;
  localparam logic [ByteW-1:0] ChLowR      = 8'h72;
  localparam logic [ByteW-1:0] ChLowT      = 8'h74;
  localparam logic [ByteW-1:0] ChLowU      = 8'h75;
  localparam logic [ByteW-1:0] ChSpace     = 8'h20;

  // Decoder phase
  typedef enum logic [3:0] {
    PH_WAIT    = 4'd0,
    PH_BODY    = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX_A0  = 4'd3,
    PH_HEX_A1  = 4'd4,
    PH_HEX_A2  = 4'd5,
    PH_HEX_A3  = 4'd6,
    PH_PAIR_BS = 4'd7,
    PH_PAIR_U  = 4'd8,
    PH_HEX_B0  = 4'd9,
    PH_HEX_B1  = 4'd10,
    PH_HEX_B2  = 4'd11,
    PH_HEX_B3  = 4'd12
  } phase_e;

  // Result status
  typedef enum logic [StatusW-1:0] {
    ST_MORE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  // Error codes
  typedef enum logic [ErrW-1:0] {
    ERR_UNTERMINATED = 3'd0,
    ERR_CONTROL      = 3'd1,
    ERR_TRUNC_ESC    = 3'd2,
    ERR_BAD_ESC      = 3'd3,
    ERR_TRUNC_HEX    = 3'd4,
    ERR_BAD_HEX      = 3'd5,
    ERR_UNPAIRED     = 3'd6,
    ERR_BAD_LOW      = 3'd7
  } err_e;

  // Encoded UTF-8 sequence
  typedef struct packed {
    logic [WordW-1:0]  bytes;
    logic [CountW-1:0] count;
  } utf8_t;

  // Hex digit value; bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [ByteW-1:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  // Code point to UTF-8, first byte in the low bits
  function automatic utf8_t utf8_encode(input logic [CpW-1:0] cp);
    utf8_t r;
    if (cp <= 21'h7F) begin
      r.bytes = {25'd0, cp[6:0]};
      r.count = 3'd1;
    end else if (cp <= 21'h7FF) begin
      r.bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      r.count = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      r.bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      r.count = 3'd3;
    end else begin
      r.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                 5'b11110, cp[20:18]};
      r.count = 3'd4;
    end
    return r;
  endfunction

endpackage

@@ sv/jsu_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_in_if
// Text byte channel: one byte of document text (or end of text) per beat.
// ----------------------------------------------------------------------------
interface jsu_in_if
  import jsu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ sv/jsu_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_if
// Result channel: decoded UTF-8 bytes and status, one result per beat.
// ----------------------------------------------------------------------------
interface jsu_out_if
  import jsu_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [WordW-1:0]   utf8_bytes;
  logic [CountW-1:0]  byte_count;
  logic [StatusW-1:0] status;
  logic [ErrW-1:0]    error_code;

  modport source (output valid, output utf8_bytes, output byte_count,
                  output status, output error_code, input ready);
  modport sink   (input valid, input utf8_bytes, input byte_count,
                  input status, input error_code, output ready);
endinterface

@@ sv/json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps
// An accepted text beat goes through the input register, then is decoded
//   into the result register.
// Throughput: one text byte per cycle unless result_o stalls.
// Reset (rst_ni low, asynchronous): both registers empty, decoder waiting for
//   an opening quote, hex accumulator and high surrogate cleared.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a JSON string literal byte stream into UTF-8, one result per byte.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    text_i,
  jsu_out_if.source result_o
);

  // Input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_eot_q;

  // Decode state
  phase_e      phase_q, phase_d;
  logic [15:0] hex_acc_q, hex_acc_d;
  logic [9:0]  high_sur_q, high_sur_d;

  // Result register
  logic               out_valid_q;
  logic [WordW-1:0]   bytes_q, bytes_d;
  logic [CountW-1:0]  count_q, count_d;
  status_e            status_q, status_d;
  err_e               err_q, err_d;

  logic advance;
  logic in_ready;

  // Pipeline control: result register frees when taken or empty
  assign advance  = !out_valid_q || result_o.ready;
  assign in_ready = !in_valid_q || advance;
  assign text_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && text_i.valid) begin
      in_byte_q <= text_i.text_byte;
      in_eot_q  <= text_i.end_of_text;
    end
  end

  // Decode of the registered byte
  logic [4:0]     digit;
  logic [15:0]    unit;
  logic [CpW-1:0] pair_cp;
  utf8_t          enc_unit;
  utf8_t          enc_pair;
  logic           hex_last;
  logic           hex_second;

  assign digit      = hex_value(in_byte_q);
  assign unit       = {hex_acc_q[11:0], digit[3:0]};
  assign pair_cp    = {11'(high_sur_q) + 11'h40, unit[9:0]};
  assign enc_unit   = utf8_encode(CpW'(unit));
  assign enc_pair   = utf8_encode(pair_cp);
  assign hex_last   = (phase_q == PH_HEX_A3) || (phase_q == PH_HEX_B3);
  assign hex_second = (phase_q == PH_HEX_B0) || (phase_q == PH_HEX_B1) ||
                      (phase_q == PH_HEX_B2) || (phase_q == PH_HEX_B3);

  always_comb begin
    phase_d    = phase_q;
    hex_acc_d  = hex_acc_q;
    high_sur_d = high_sur_q;
    bytes_d    = '0;
    count_d    = '0;
    status_d   = ST_MORE;
    err_d      = ERR_UNTERMINATED;

    case (phase_q)
      PH_WAIT: begin
        // first byte is taken as the opening quote
        if (!in_eot_q) begin
          phase_d = PH_BODY;
        end
      end

      PH_BODY: begin
        if (in_eot_q) begin
          status_d = ST_ERROR;
          err_d    = ERR_UNTERMINATED;
          phase_d  = PH_WAIT;
        end else if (in_byte_q == ChQuote) begin
          status_d = ST_DONE;
          phase_d  = PH_WAIT;
        end else if (in_byte_q < ChSpace) begin
          status_d = ST_ERROR;
          err_d    = ERR_CONTROL;
          phase_d  = PH_WAIT;
        end else if (in_byte_q == ChBackslash) begin
          phase_d = PH_ESC;
        end else begin
          bytes_d = WordW'(in_byte_q);
          count_d = 3'd1;
        end
      end

      PH_ESC: begin
        phase_d = PH_BODY;
        count_d = 3'd1;
        if (in_eot_q) begin
          status_d = ST_ERROR;
          err_d    = ERR_TRUNC_ESC;
          count_d  = '0;
          phase_d  = PH_WAIT;
        end else begin
          case (in_byte_q)
            ChQuote, ChBackslash, ChSlash: bytes_d = WordW'(in_byte_q);
            ChLowB: bytes_d = WordW'(8'h08);
            ChLowF: bytes_d = WordW'(8'h0C);
            ChLowN: bytes_d = WordW'(8'h0A);
            ChLowR: bytes_d = WordW'(8'h0D);
            ChLowT: bytes_d = WordW'(8'h09);
            ChLowU: begin
              count_d   = '0;
              hex_acc_d = '0;
              phase_d   = PH_HEX_A0;
            end
            default: begin
              status_d = ST_ERROR;
              err_d    = ERR_BAD_ESC;
              count_d  = '0;
              phase_d  = PH_WAIT;
            end
          endcase
        end
      end

      PH_PAIR_BS: begin
        if (in_eot_q || in_byte_q != ChBackslash) begin
          status_d = ST_ERROR;
          err_d    = ERR_UNPAIRED;
          phase_d  = PH_WAIT;
        end else begin
          phase_d = PH_PAIR_U;
        end
      end

      PH_PAIR_U: begin
        if (in_eot_q || in_byte_q != ChLowU) begin
          status_d = ST_ERROR;
          err_d    = ERR_UNPAIRED;
          phase_d  = PH_WAIT;
        end else begin
          hex_acc_d = '0;
          phase_d   = PH_HEX_B0;
        end
      end

      PH_HEX_A0, PH_HEX_A1, PH_HEX_A2, PH_HEX_A3,
      PH_HEX_B0, PH_HEX_B1, PH_HEX_B2, PH_HEX_B3: begin
        if (in_eot_q) begin
          status_d = ST_ERROR;
          err_d    = ERR_TRUNC_HEX;
          phase_d  = PH_WAIT;
        end else if (digit[4]) begin
          status_d = ST_ERROR;
          err_d    = ERR_BAD_HEX;
          phase_d  = PH_WAIT;
        end else if (!hex_last) begin
          hex_acc_d = unit;
          phase_d   = phase_e'(4'(phase_q) + 4'd1);
        end else if (!hex_second) begin
          // first unit complete
          hex_acc_d = '0;
          if (unit[15:10] == 6'b110110) begin
            high_sur_d = unit[9:0];
            phase_d    = PH_PAIR_BS;
          end else if (unit[15:10] == 6'b110111) begin
            status_d = ST_ERROR;
            err_d    = ERR_UNPAIRED;
            phase_d  = PH_WAIT;
          end else begin
            bytes_d = enc_unit.bytes;
            count_d = enc_unit.count;
            phase_d = PH_BODY;
          end
        end else begin
          // low surrogate unit complete
          hex_acc_d = '0;
          if (unit[15:10] != 6'b110111) begin
            status_d = ST_ERROR;
            err_d    = ERR_BAD_LOW;
            phase_d  = PH_WAIT;
          end else begin
            bytes_d    = enc_pair.bytes;
            count_d    = enc_pair.count;
            high_sur_d = '0;
            phase_d    = PH_BODY;
          end
        end
      end

      default: begin
        phase_d = PH_WAIT;
      end
    endcase

    // returning to wait clears the scratch state
    if (phase_d == PH_WAIT) begin
      hex_acc_d  = '0;
      high_sur_d = '0;
    end
  end

  // State and result valid update on each decoded beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      hex_acc_q   <= '0;
      high_sur_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        phase_q    <= phase_d;
        hex_acc_q  <= hex_acc_d;
        high_sur_q <= high_sur_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      bytes_q  <= bytes_d;
      count_q  <= count_d;
      status_q <= status_d;
      err_q    <= err_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.utf8_bytes = bytes_q;
  assign result_o.byte_count = count_q;
  assign result_o.status     = status_q;
  assign result_o.error_code = err_q;

  // Checks
  a_err_code_only_on_error: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_ERROR) |-> (err_q == ERR_UNTERMINATED)
  ) else $error("error code set without error status");

  a_no_bytes_on_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_MORE) |-> (count_q == '0 && bytes_q == '0)
  ) else $error("bytes emitted with completion or error");

  a_stall_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (in_valid_q && out_valid_q && !result_o.ready)
  ) else $error("input stalled while pipeline can move");

  a_wait_clears_scratch: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT) |-> (hex_acc_q == '0 && high_sur_q == '0)
  ) else $error("scratch state not cleared while waiting");

endmodule

@@ dv/json_string_unescape_utf8_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// Self-checking bench for the JSON string unescaper. A directed set of text
// bytes comes first, then random strings: mostly well-formed literals with
// plain bytes, simple escapes, \u units and surrogate pairs, plus broken
// strings that hit every error code. An in-bench decoder predicts each
// result beat. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  typedef struct {
    logic [31:0] bytes;
    logic [2:0]  count;
    status_e     status;
    err_e        err;
  } decoded_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_in_if  text_if ();
  jsu_out_if result_if ();

  json_string_unescape_utf8 u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .result_o (result_if)
  );

  always #10 clk_i = ~clk_i;

  text_item_t  text_q[$];
  decoded_t    decoded_q[$];
  int unsigned total_items;
  int unsigned sent_cnt   = 0;
  int unsigned bad_cnt    = 0;
  bit          text_taken = 1'b0;
  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;
  int unsigned in_calm    = 0;
  int unsigned out_calm   = 0;

  // Decoder state mirrored by the bench
  phase_e      dec_phase = PH_WAIT;
  logic [15:0] hex_acc   = '0;
  logic [9:0]  hi_sur    = '0;

  // Hex digit value; bit 4 set marks a non-digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'h10;
  endfunction

  function automatic void to_utf8(input logic [20:0] cp, output logic [31:0] w,
                                  output logic [2:0] n);
    logic [7:0] b0, b1, b2, b3;
    if (cp < 21'h80) begin
      w = {24'd0, cp[7:0]};
      n = 3'd1;
    end else if (cp < 21'h800) begin
      b0 = 8'hC0 | 8'(cp >> 6);
      b1 = 8'h80 | 8'(cp[5:0]);
      w  = {16'd0, b1, b0};
      n  = 3'd2;
    end else if (cp < 21'h10000) begin
      b0 = 8'hE0 | 8'(cp >> 12);
      b1 = 8'h80 | 8'(cp[11:6]);
      b2 = 8'h80 | 8'(cp[5:0]);
      w  = {8'd0, b2, b1, b0};
      n  = 3'd3;
    end else begin
      b0 = 8'hF0 | 8'(cp[20:18]);
      b1 = 8'h80 | 8'(cp[17:12]);
      b2 = 8'h80 | 8'(cp[11:6]);
      b3 = 8'h80 | 8'(cp[5:0]);
      w  = {b3, b2, b1, b0};
      n  = 3'd4;
    end
  endfunction

  // One text beat through the decoder: returns its result beat
  function automatic decoded_t decode_beat(input logic [7:0] c, input logic eot);
    decoded_t    r;
    logic        fault, closing;
    err_e        code;
    logic [4:0]  d;
    logic [15:0] unit;
    r.bytes  = '0;
    r.count  = '0;
    r.status = ST_MORE;
    r.err    = ERR_UNTERMINATED;
    fault    = 1'b0;
    closing  = 1'b0;
    code     = ERR_UNTERMINATED;
    case (dec_phase)
      PH_WAIT: begin
        if (!eot) dec_phase = PH_BODY;
      end
      PH_BODY: begin
        if (eot) begin
          fault = 1'b1; code = ERR_UNTERMINATED;
        end else if (c == ChQuote) begin
          closing = 1'b1;
        end else if (c < ChSpace) begin
          fault = 1'b1; code = ERR_CONTROL;
        end else if (c == ChBackslash) begin
          dec_phase = PH_ESC;
        end else begin
          r.bytes = {24'd0, c};
          r.count = 3'd1;
        end
      end
      PH_ESC: begin
        if (eot) begin
          fault = 1'b1; code = ERR_TRUNC_ESC;
        end else if (c == ChLowU) begin
          hex_acc   = '0;
          dec_phase = PH_HEX_A0;
        end else begin
          r.count = 3'd1;
          case (c)
            ChQuote, ChBackslash, ChSlash: r.bytes = {24'd0, c};
            ChLowB: r.bytes = 32'h08;   // backspace
            ChLowF: r.bytes = 32'h0C;   // form feed
            ChLowN: r.bytes = 32'h0A;   // line feed
            ChLowR: r.bytes = 32'h0D;   // carriage return
            ChLowT: r.bytes = 32'h09;   // tab
            default: begin
              fault = 1'b1; code = ERR_BAD_ESC;
            end
          endcase
          dec_phase = PH_BODY;
        end
      end
      PH_PAIR_BS: begin
        if (eot || c != ChBackslash) begin
          fault = 1'b1; code = ERR_UNPAIRED;
        end else begin
          dec_phase = PH_PAIR_U;
        end
      end
      PH_PAIR_U: begin
        if (eot || c != ChLowU) begin
          fault = 1'b1; code = ERR_UNPAIRED;
        end else begin
          hex_acc   = '0;
          dec_phase = PH_HEX_B0;
        end
      end
      PH_HEX_A0, PH_HEX_A1, PH_HEX_A2, PH_HEX_A3,
      PH_HEX_B0, PH_HEX_B1, PH_HEX_B2, PH_HEX_B3: begin
        d = hex_digit(c);
        if (eot) begin
          fault = 1'b1; code = ERR_TRUNC_HEX;
        end else if (d[4]) begin
          fault = 1'b1; code = ERR_BAD_HEX;
        end else begin
          unit    = {hex_acc[11:0], d[3:0]};
          hex_acc = unit;
          if (dec_phase != PH_HEX_A3 && dec_phase != PH_HEX_B3) begin
            dec_phase = phase_e'(dec_phase + 4'd1);
          end else begin
            hex_acc = '0;
            if (dec_phase == PH_HEX_A3) begin
              // first unit: high surrogate waits for its partner
              if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                hi_sur    = 10'(unit - 16'hD800);
                dec_phase = PH_PAIR_BS;
              end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                fault = 1'b1; code = ERR_UNPAIRED;
              end else begin
                to_utf8(21'(unit), r.bytes, r.count);
                dec_phase = PH_BODY;
              end
            end else if (unit < 16'hDC00 || unit > 16'hDFFF) begin
              fault = 1'b1; code = ERR_BAD_LOW;
            end else begin
              to_utf8(21'h10000 + 21'({hi_sur, 10'd0}) + 21'(unit - 16'hDC00),
                      r.bytes, r.count);
              hi_sur    = '0;
              dec_phase = PH_BODY;
            end
          end
        end
      end
      default: begin
        dec_phase = PH_WAIT;
        hex_acc   = '0;
        hi_sur    = '0;
      end
    endcase
    if (fault) begin
      r.bytes  = '0;
      r.count  = '0;
      r.status = ST_ERROR;
      r.err    = code;
    end else if (closing) begin
      r.status = ST_DONE;
    end
    if (fault || closing) begin
      dec_phase = PH_WAIT;
      hex_acc   = '0;
      hi_sur    = '0;
    end
    return r;
  endfunction

  // Gap length: mostly short, a few long, with calm stretches of none
  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic void push(input logic [7:0] c, input logic e);
    text_item_t it;
    it.ch  = c;
    it.eot = e;
    text_q = {text_q, it};
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return 8'h30 + 8'(d);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(d) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    logic [4:0] d;
    do begin
      c = rand_byte();
      d = hex_digit(c);
    end while (!d[4]);
    return c;
  endfunction

  function automatic void push_hex(input logic [15:0] v);
    push(hex_char(v[15:12]), 1'b0);
    push(hex_char(v[11:8]), 1'b0);
    push(hex_char(v[7:4]), 1'b0);
    push(hex_char(v[3:0]), 1'b0);
  endfunction

  function automatic void push_u(input logic [15:0] v);
    push(ChBackslash, 1'b0);
    push(ChLowU, 1'b0);
    push_hex(v);
  endfunction

  // \u with only some digits, then end of text or a non-digit
  function automatic void push_short_hex();
    int unsigned k;
    k = $urandom_range(0, 3);
    repeat (k) push(hex_char(4'($urandom_range(0, 15))), 1'b0);
    if ($urandom_range(0, 1)) push(rand_byte(), 1'b1);
    else push(non_hex_byte(), 1'b0);
  endfunction

  function automatic logic [15:0] rand_bmp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hD7FF));
      3: return 16'($urandom_range(16'hE000, 16'hFFFF));
      4: begin
        case ($urandom_range(0, 7))
          0: return 16'h0000;
          1: return 16'h007F;
          2: return 16'h0080;
          3: return 16'h07FF;
          4: return 16'h0800;
          5: return 16'hD7FF;
          6: return 16'hE000;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom_range(16'h0000, 16'hD7FF));
    endcase
  endfunction

  function automatic logic [15:0] rand_high();
    case ($urandom_range(0, 5))
      0: return 16'hD800;
      1: return 16'hDBFF;
      default: return 16'($urandom_range(16'hD800, 16'hDBFF));
    endcase
  endfunction

  function automatic logic [15:0] rand_low();
    case ($urandom_range(0, 5))
      0: return 16'hDC00;
      1: return 16'hDFFF;
      default: return 16'($urandom_range(16'hDC00, 16'hDFFF));
    endcase
  endfunction

  function automatic logic [7:0] escape_letter();
    case ($urandom_range(0, 7))
      0: return ChQuote;
      1: return ChBackslash;
      2: return ChSlash;
      3: return ChLowB;
      4: return ChLowF;
      5: return ChLowN;
      6: return ChLowR;
      default: return ChLowT;
    endcase
  endfunction

  function automatic logic [7:0] bad_escape_letter();
    logic [7:0] c;
    do c = rand_byte();
    while (c == ChQuote || c == ChBackslash || c == ChSlash || c == ChLowB ||
           c == ChLowF || c == ChLowN || c == ChLowR || c == ChLowT ||
           c == ChLowU);
    return c;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'hFF));
    while (c == ChQuote || c == ChBackslash);
    return c;
  endfunction

  // A broken ending for a string body
  function automatic void push_fault();
    logic [7:0] c;
    logic [15:0] v;
    case ($urandom_range(0, 10))
      0: push(rand_byte(), 1'b1);
      1: push(8'($urandom_range(0, 31)), 1'b0);
      2: begin
        push(ChBackslash, 1'b0);
        push(rand_byte(), 1'b1);
      end
      3: begin
        push(ChBackslash, 1'b0);
        // control bytes after a backslash are bad escapes too
        if ($urandom_range(0, 2) == 0) push(8'($urandom_range(0, 31)), 1'b0);
        else push(bad_escape_letter(), 1'b0);
      end
      4, 5: begin
        push(ChBackslash, 1'b0);
        push(ChLowU, 1'b0);
        push_short_hex();
      end
      6: push_u(rand_low());
      7: begin
        push_u(rand_high());
        do c = rand_byte(); while (c == ChBackslash);
        push(c, $urandom_range(0, 1) ? 1'b1 : 1'b0);
      end
      8: begin
        push_u(rand_high());
        push(ChBackslash, 1'b0);
        do c = rand_byte(); while (c == ChLowU);
        push(c, $urandom_range(0, 1) ? 1'b1 : 1'b0);
      end
      9: begin
        push_u(rand_high());
        if ($urandom_range(0, 1)) v = 16'($urandom_range(16'h0000, 16'hDBFF));
        else v = 16'($urandom_range(16'hE000, 16'hFFFF));
        push_u(v);
      end
      default: begin
        push_u(rand_high());
        push(ChBackslash, 1'b0);
        push(ChLowU, 1'b0);
        push_short_hex();
      end
    endcase
  endfunction

  function automatic void push_string();
    int unsigned n_tok;
    // any byte opens a string, usually the quote
    if ($urandom_range(0, 9) == 0) push(rand_byte(), 1'b0);
    else push(ChQuote, 1'b0);
    n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    repeat (n_tok) begin
      case ($urandom_range(0, 6))
        0, 1, 2: push(plain_byte(), 1'b0);
        3: begin
          push(ChBackslash, 1'b0);
          push(escape_letter(), 1'b0);
        end
        4, 5: push_u(rand_bmp());
        default: begin
          push_u(rand_high());
          push_u(rand_low());
        end
      endcase
    end
    if ($urandom_range(0, 99) < 70) push(ChQuote, 1'b0);
    else push_fault();
    // end of text between strings is ignored
    if ($urandom_range(0, 9) == 0) push(rand_byte(), 1'b1);
  endfunction

  // ---------------- text channel driver ----------------
  always @(negedge clk_i) begin : drive_text
    text_item_t nxt;
    if (rst_ni && (text_taken || !text_if.valid)) begin
      text_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        text_if.valid <= 1'b0;
      end else if (text_q.size() > 0) begin
        nxt = text_q.pop_front();
        text_if.valid       <= 1'b1;
        text_if.text_byte   <= nxt.ch;
        text_if.end_of_text <= nxt.eot;
        send_gap = pick_gap(in_calm);
      end else begin
        text_if.valid <= 1'b0;
      end
    end
  end

  // Accepted text beat: predict its result
  always @(posedge clk_i) begin : predict_result
    decoded_t pred;
    if (rst_ni && text_if.valid && text_if.ready) begin
      pred      = decode_beat(text_if.text_byte, text_if.end_of_text);
      decoded_q = {decoded_q, pred};
      text_taken = 1'b1;
      sent_cnt++;
    end
  end

  // ---------------- result channel ----------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        stall_left = pick_gap(out_calm);
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    decoded_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (decoded_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) begin
          $display("%0t: unexpected result beat bytes=%h count=%0d status=%0d err=%0d",
                   $realtime, result_if.utf8_bytes, result_if.byte_count,
                   result_if.status, result_if.error_code);
        end
      end else begin
        want = decoded_q.pop_front();
        if (result_if.utf8_bytes !== want.bytes || result_if.byte_count !== want.count ||
            result_if.status !== want.status || result_if.error_code !== want.err) begin
          bad_cnt++;
          if (bad_cnt <= 10) begin
            $display("%0t: result mismatch exp bytes=%h count=%0d status=%0d err=%0d",
                     $realtime, want.bytes, want.count, want.status, want.err);
            $display("%0t:                 got bytes=%h count=%0d status=%0d err=%0d",
                     $realtime, result_if.utf8_bytes, result_if.byte_count,
                     result_if.status, result_if.error_code);
          end
        end
      end
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    rst_ni                = 1'b0;
    text_if.valid         = 1'b0;
    text_if.text_byte     = '0;
    text_if.end_of_text   = 1'b0;
    result_if.ready       = 1'b0;

    // directed: end of text while waiting, high plain bytes, an escape,
    // a surrogate pair, a control byte after a backslash, a lone low surrogate
    push(8'h00, 1'b1);
    push(ChQuote, 1'b0);
    push(8'hFF, 1'b0);
    push(8'h80, 1'b0);
    push(ChSpace, 1'b0);
    push(ChBackslash, 1'b0);
    push(ChLowN, 1'b0);
    push_u(16'hD83D);
    push_u(16'hdE00);
    push(ChQuote, 1'b0);
    push(ChQuote, 1'b0);
    push(ChBackslash, 1'b0);
    push(8'h01, 1'b0);
    push(8'hFF, 1'b0);
    push_u(16'hDC00);

    // random strings and a little noise
    while (text_q.size() < 430) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 6)) push(rand_byte(), $urandom_range(0, 3) == 0);
      end else begin
        push_string();
      end
    end
    total_items = text_q.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (sent_cnt == total_items);
    wait (decoded_q.size() == 0);
    repeat (8) @(posedge clk_i);
    if (bad_cnt == 0) begin
      $display("json_string_unescape_utf8_tb passed");
    end else begin
      $display("json_string_unescape_utf8_tb failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("json_string_unescape_utf8_tb failed");
    $finish;
  end

endmodule
